>>> rtl/dbtdc_pkg.sv
// Package for the decimate-by-three DC remover: payload structs, register
// codes, controller states, shared constants and the arithmetic helpers.
// No dependencies.
package dbtdc_pkg;

  localparam int unsigned SAMPLE_W        = 32;
  localparam int unsigned DECIMATION      = 3;
  localparam int unsigned DC_DENOM        = 1000;
  localparam int unsigned DC_KEEP         = 999;
  localparam int unsigned MAX_CHANNELS    = 2;
  localparam int unsigned MAX_BLOCK_SAMPS = 1024;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 2;

  // floor(n / DC_DENOM) for any 32-bit unsigned n
  localparam logic [31:0] DC_RECIP    = 32'h1062_4DD3;
  localparam int unsigned DC_RECIP_SH = 38;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 1'b0,
    CFG_DC_ENABLE     = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_AVG_GO,
    S_AVG_WAIT,
    S_SCALE,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic                       block_end;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } out_rsp_t;

  function automatic logic signed [SAMPLE_W-1:0] sat32(logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      return hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] div_denom(logic [SAMPLE_W-1:0] n);
    logic [63:0] p;
    p = 64'(n) * 64'(DC_RECIP);
    return SAMPLE_W'(p >> DC_RECIP_SH);
  endfunction

endpackage

>>> rtl/dbtdc_lane.sv
// One channel lane: three-tap sample history and the 1-2-1 filter / 4.
// Depends on dbtdc_pkg.
module dbtdc_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [1:0]                           wr_idx_i,
  input  logic signed [dbtdc_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [dbtdc_pkg::SAMPLE_W-1:0] raw_o
);

  logic signed [dbtdc_pkg::SAMPLE_W-1:0] hist_q [3];
  logic signed [dbtdc_pkg::SAMPLE_W+1:0] acc;
  logic signed [dbtdc_pkg::SAMPLE_W+1:0] acc_adj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q[0] <= '0;
      hist_q[1] <= '0;
      hist_q[2] <= '0;
    end else if (wr_en_i) begin
      hist_q[wr_idx_i] <= sample_i;
    end
  end

  always_comb begin
    acc = 34'(hist_q[0]) + (34'(hist_q[1]) <<< 1) + 34'(hist_q[2]);
    // truncate toward zero
    acc_adj = acc + (acc[33] ? 34'sd3 : 34'sd0);
  end

  assign raw_o = acc_adj[33:2];

endmodule

>>> rtl/dbtdc_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Positive divisor only. Depends on nothing.
module dbtdc_div #(
  parameter int unsigned DivW = 42,
  parameter int unsigned DvsW = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0]        divisor_i,
  output logic                   done_o,
  output logic signed [DivW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(DivW);

  logic             busy_q, done_q, neg_q;
  logic [StepW-1:0] step_q;
  logic [DvsW-1:0]  rem_q, dvs_q;
  logic [DivW-1:0]  quo_q;
  logic [DvsW:0]    rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DivW-1];
      quo_q <= dividend_i[DivW-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DvsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvsW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

>>> rtl/decimate_by_three_dc_remover_core.sv
// Top level of the decimate-by-three DC remover: channel lanes, merge stage,
// block accumulator and offset update sequencer.
// Depends on dbtdc_pkg, dbtdc_lane, dbtdc_div.
//
//   channel  | signals                          | moves
//   ---------+----------------------------------+-------------------------
//   input    | in_valid_i  in_ready_o  in_req_i | one frame request
//   output   | out_valid_o out_ready_i out_rsp_o| one decimated result
//   config   | cfg_valid_i cfg_ready_o          | register index and data
//
// A frame is accepted and written to history in S_IDLE, then filtered, merged
// and loaded to the output in S_FILT. A block-end frame with correction on adds
// one serial divide of the block sum by the count (S_AVG_GO, S_AVG_WAIT), then
// two reciprocal multiplies in S_SCALE and the estimate update in S_UPDATE.
// A result waiting in the output register stalls only the next frame that emits.
// Reset clears history, phase, estimate and block accumulator; config is always ready.
module decimate_by_three_dc_remover_core #(
  parameter int unsigned MaxChannels     = dbtdc_pkg::MAX_CHANNELS,
  parameter int unsigned MaxBlockSamples = dbtdc_pkg::MAX_BLOCK_SAMPS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dbtdc_pkg::in_req_t                  in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dbtdc_pkg::out_rsp_t                 out_rsp_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dbtdc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dbtdc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned SW    = dbtdc_pkg::SAMPLE_W;
  localparam int unsigned CntW  = $clog2(MaxBlockSamples + 1);
  localparam int unsigned SumW  = SW + CntW;
  localparam int unsigned DivW  = (SumW > 42) ? SumW : 42;
  localparam int unsigned DvsW  = (CntW > 10) ? CntW : 10;

  dbtdc_pkg::state_e state_q, state_d;

  logic [1:0] chan_cfg_q;
  logic       dc_en_q;
  logic [1:0] phase_q, phase_d;
  logic [1:0] fill_q, fill_d;
  logic       emit_q, end_q, stereo_q;
  logic       stereo;
  logic       accept;

  logic signed [SW-1:0]   raw [2];
  logic signed [SW-1:0]   dc_est_q;
  logic signed [SumW-1:0] sum_q, sum_a, sum_b;
  logic [CntW-1:0]        cnt_q, cnt_a, cnt_b;
  logic signed [DivW-1:0] tmp_q;

  logic signed [SW-1:0]   avg_s, avg_scaled, est_dec, decay_q;
  logic [SW-1:0]          avg_mag, avg_quo, est_mag, est_ceil;

  logic                   out_valid_q;
  dbtdc_pkg::out_rsp_t    out_q, out_d;
  logic                   out_load;

  logic                   div_start, div_done;
  logic signed [DivW-1:0] div_a, div_q;
  logic [DvsW-1:0]        div_b;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == dbtdc_pkg::S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign stereo      = (MaxChannels > 1) && chan_cfg_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cfg_q <= 2'd1;
      dc_en_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (dbtdc_pkg::cfg_reg_e'(cfg_index_i))
        dbtdc_pkg::CFG_CHANNEL_COUNT: chan_cfg_q <= cfg_data_i;
        dbtdc_pkg::CFG_DC_ENABLE:     dc_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // lanes
  dbtdc_lane u_lane0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept),
    .wr_idx_i (phase_q),
    .sample_i (in_req_i.sample_left),
    .raw_o    (raw[0])
  );

  if (MaxChannels > 1) begin : g_lane1
    dbtdc_lane u_lane1 (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (accept && stereo),
      .wr_idx_i (phase_q),
      .sample_i (in_req_i.sample_right),
      .raw_o    (raw[1])
    );
  end else begin : g_no_lane1
    assign raw[1] = '0;
  end

  always_comb begin
    phase_d = (phase_q == 2'(dbtdc_pkg::DECIMATION - 1)) ? 2'd0 : phase_q + 2'd1;
    fill_d  = (fill_q == 2'(dbtdc_pkg::DECIMATION)) ? fill_q : fill_q + 2'd1;
  end

  // merge: block accumulate and correction
  always_comb begin
    sum_a = sum_q;
    cnt_a = cnt_q;
    if (emit_q && cnt_q < CntW'(MaxBlockSamples)) begin
      sum_a = sum_q + SumW'(raw[0]);
      cnt_a = cnt_q + 1'b1;
    end
    sum_b = sum_a;
    cnt_b = cnt_a;
    if (emit_q && stereo_q && cnt_a < CntW'(MaxBlockSamples)) begin
      sum_b = sum_a + SumW'(raw[1]);
      cnt_b = cnt_a + 1'b1;
    end
    out_d.out_left  = dc_en_q ? dbtdc_pkg::sat32(64'(raw[0]) - 64'(dc_est_q)) : raw[0];
    out_d.out_right = !stereo_q ? '0 :
                      dc_en_q ? dbtdc_pkg::sat32(64'(raw[1]) - 64'(dc_est_q)) : raw[1];
  end

  // estimate terms: trunc(avg/1000) and trunc(999*est/1000) = est -+ ceil(|est|/1000)
  always_comb begin
    avg_s      = tmp_q[SW-1:0];
    avg_mag    = avg_s[SW-1] ? -avg_s : avg_s;
    avg_quo    = dbtdc_pkg::div_denom(avg_mag);
    avg_scaled = avg_s[SW-1] ? -$signed(avg_quo) : $signed(avg_quo);
    est_mag    = dc_est_q[SW-1] ? -dc_est_q : dc_est_q;
    est_ceil   = dbtdc_pkg::div_denom(est_mag + SW'(dbtdc_pkg::DC_DENOM - 1));
    est_dec    = dc_est_q[SW-1] ? dc_est_q + $signed(est_ceil) :
                                  dc_est_q - $signed(est_ceil);
  end

  // controller
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbtdc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    out_load  = 1'b0;
    div_start = 1'b0;
    div_a     = DivW'(sum_q);
    div_b     = DvsW'(cnt_q);
    case (state_q)
      dbtdc_pkg::S_IDLE: begin
        if (accept) state_d = dbtdc_pkg::S_FILT;
      end
      dbtdc_pkg::S_FILT: begin
        if (!emit_q || !out_valid_q || out_ready_i) begin
          out_load = emit_q;
          if (end_q && dc_en_q && cnt_b != '0) state_d = dbtdc_pkg::S_AVG_GO;
          else state_d = dbtdc_pkg::S_IDLE;
        end
      end
      dbtdc_pkg::S_AVG_GO: begin
        div_start = 1'b1;
        state_d   = dbtdc_pkg::S_AVG_WAIT;
      end
      dbtdc_pkg::S_AVG_WAIT: begin
        if (div_done) state_d = dbtdc_pkg::S_SCALE;
      end
      dbtdc_pkg::S_SCALE: begin
        state_d = dbtdc_pkg::S_UPDATE;
      end
      dbtdc_pkg::S_UPDATE: begin
        state_d = dbtdc_pkg::S_IDLE;
      end
      default: state_d = dbtdc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      fill_q      <= '0;
      emit_q      <= 1'b0;
      end_q       <= 1'b0;
      stereo_q    <= 1'b0;
      dc_est_q    <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        fill_q   <= fill_d;
        emit_q   <= (phase_d == 2'd0) && (fill_d == 2'(dbtdc_pkg::DECIMATION));
        end_q    <= in_req_i.block_end;
        stereo_q <= stereo;
      end
      if (state_q == dbtdc_pkg::S_FILT && state_d != dbtdc_pkg::S_FILT) begin
        if (end_q && state_d != dbtdc_pkg::S_AVG_GO) begin
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= sum_b;
          cnt_q <= cnt_b;
        end
      end
      if (state_q == dbtdc_pkg::S_AVG_GO) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
      if (state_q == dbtdc_pkg::S_UPDATE) begin
        dc_est_q <= dbtdc_pkg::sat32(64'(tmp_q) + 64'(decay_q));
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
    if (div_done && state_q == dbtdc_pkg::S_AVG_WAIT) tmp_q <= div_q;
    if (state_q == dbtdc_pkg::S_SCALE) begin
      tmp_q   <= DivW'(avg_scaled);
      decay_q <= est_dec;
    end
  end

  dbtdc_div #(
    .DivW (DivW),
    .DvsW (DvsW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBlockSamples))
    else $error("block count beyond bound");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == dbtdc_pkg::S_AVG_WAIT)
    else $error("divider finished outside a wait state");

  a_est_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(dc_est_q) |-> $past(state_q) == dbtdc_pkg::S_UPDATE)
    else $error("estimate changed outside update");

  a_block_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbtdc_pkg::S_FILT && end_q && state_d == dbtdc_pkg::S_IDLE) |=> cnt_q == '0)
    else $error("block count not cleared at block end");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbtdc_pkg::S_FILT && emit_q && out_valid_q && !out_ready_i) |=> !out_load ||
    state_q == dbtdc_pkg::S_FILT)
    else $error("result lost while output stalled");

endmodule
